FILE: design/dhh_pkg.sv
// dhh_pkg: shared types and constants for the dominant hue histogram block.
// Used by dhh_ctrl, dhh_datapath, dominant_hue_histogram and dhh_checker.
package dhh_pkg;

  localparam int COUNT_BITS = 26;
  localparam int NUM_BINS   = 8;
  localparam int BIN_BITS   = 3;
  localparam int FRAC_BITS  = 16;
  localparam int STEP_BITS  = 4;
  localparam int HUE_BITS   = 17;   // hue scaled by delta, below 360*255
  localparam int M30_BITS   = 13;   // 30*delta

  localparam logic [BIN_BITS-1:0] LAST_BIN = BIN_BITS'(NUM_BINS - 1);

  // Hue centers in units of 30 degrees: 0,30,60,120,180,240,270,300
  localparam logic [3:0] CENTER_UNIT [NUM_BINS] = '{
    4'd0, 4'd1, 4'd2, 4'd4, 4'd6, 4'd8, 4'd9, 4'd10
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_pixel;
  } pixel_t;

  typedef struct packed {
    logic [BIN_BITS-1:0]  bin_index;
    logic [FRAC_BITS-1:0] fraction;
    logic                 last_bin;
  } result_t;

  typedef struct packed {
    logic                accept;
    logic                load;
    logic                step;
    logic                clear;
    logic [BIN_BITS-1:0] bin;
  } cmd_t;

endpackage

FILE: design/dhh_ctrl.sv
// dhh_ctrl: state machine that sequences streaming, pipeline drain and
// the per-bin normalization division. Depends on dhh_pkg.
module dhh_ctrl import dhh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic last_pixel,
  output logic busy,
  output logic result_valid,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_RUN   = 5'b00001,
    ST_DRAIN = 5'b00010,
    ST_LOAD  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t              state, state_next;
  logic [STEP_BITS-1:0] cnt, cnt_next;
  logic [BIN_BITS-1:0]  bin, bin_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    bin_next   = bin;
    cmd        = '0;
    cmd.bin    = bin;
    busy       = 1'b1;
    result_valid = 1'b0;
    unique case (state)
      ST_RUN: begin
        busy       = 1'b0;
        cmd.accept = start;
        if (start && last_pixel) begin
          state_next = ST_DRAIN;
          cnt_next   = '0;
          bin_next   = '0;
        end
      end
      ST_DRAIN: begin
        // wait for the hue pipeline to reach the bin counters
        if (cnt == STEP_BITS'(1)) begin
          state_next = ST_LOAD;
        end else begin
          cnt_next = cnt + STEP_BITS'(1);
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (cnt == STEP_BITS'(FRAC_BITS - 1)) begin
          state_next = ST_EMIT;
        end else begin
          cnt_next = cnt + STEP_BITS'(1);
        end
      end
      ST_EMIT: begin
        result_valid = 1'b1;
        if (bin == LAST_BIN) begin
          cmd.clear  = 1'b1;
          state_next = ST_RUN;
        end else begin
          bin_next   = bin + BIN_BITS'(1);
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      cnt   <= '0;
      bin   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      bin   <= bin_next;
    end
  end

endmodule

FILE: design/dhh_datapath.sv
// dhh_datapath: two-stage hue binning pipeline, saturating counters and a
// restoring divider that forms one quotient bit per cycle. Depends on dhh_pkg.
module dhh_datapath import dhh_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cmd_t    cmd,
  input  pixel_t  pixel,
  output result_t result
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // stage 1: max/min, delta and scaled hue
  logic [7:0]         mx, mn, d;
  logic signed [18:0] hs;
  logic               v1, gray_q;
  logic [HUE_BITS-1:0] h_q;
  logic [7:0]         d_q;

  always_comb begin
    mx = pixel.red;
    mn = pixel.red;
    if (pixel.green > mx) mx = pixel.green;
    if (pixel.blue > mx)  mx = pixel.blue;
    if (pixel.green < mn) mn = pixel.green;
    if (pixel.blue < mn)  mn = pixel.blue;
    d = mx - mn;
    if (mx == pixel.red) begin
      hs = 19'sd60 * ($signed({11'b0, pixel.green}) - $signed({11'b0, pixel.blue}));
      if (hs < 0) hs = hs + 19'sd360 * $signed({11'b0, d});
    end else if (mx == pixel.green) begin
      hs = 19'sd60 * ($signed({11'b0, pixel.blue}) - $signed({11'b0, pixel.red}))
           + 19'sd120 * $signed({11'b0, d});
    end else begin
      hs = 19'sd60 * ($signed({11'b0, pixel.red}) - $signed({11'b0, pixel.green}))
           + 19'sd240 * $signed({11'b0, d});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= cmd.accept;
    end
    h_q    <= hs[HUE_BITS-1:0];
    d_q    <= d;
    gray_q <= (d == 8'd0);
  end

  // stage 2: open interval test around each center, bounds are multiples of 30*delta
  logic [M30_BITS-1:0] m30;
  logic [HUE_BITS-1:0] m30w;
  logic [NUM_BINS-1:0] hit, hit_q;

  assign m30  = M30_BITS'(d_q) * M30_BITS'(30);
  assign m30w = HUE_BITS'(m30);

  always_comb begin
    for (int i = 0; i < NUM_BINS; i++) begin
      if (CENTER_UNIT[i] == 4'd0) begin
        hit[i] = (h_q < m30w) || (h_q > m30w * HUE_BITS'(11));
      end else begin
        hit[i] = (h_q > m30w * HUE_BITS'(CENTER_UNIT[i] - 4'd1)) &&
                 (h_q < m30w * HUE_BITS'(CENTER_UNIT[i] + 4'd1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_q <= '0;
    end else begin
      hit_q <= (v1 && !gray_q) ? hit : '0;
    end
  end

  // counters
  logic [COUNT_BITS-1:0] total;
  logic [COUNT_BITS-1:0] counts [NUM_BINS];

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      total <= '0;
      for (int i = 0; i < NUM_BINS; i++) counts[i] <= '0;
    end else begin
      if (cmd.accept && total != COUNT_MAX) total <= total + COUNT_BITS'(1);
      for (int i = 0; i < NUM_BINS; i++) begin
        if (hit_q[i] && counts[i] != COUNT_MAX) counts[i] <= counts[i] + COUNT_BITS'(1);
      end
    end
  end

  // restoring divider: count * 2^16 / total; count never exceeds total,
  // so equal values come out as all ones
  logic [COUNT_BITS:0]    rem, rem2;
  logic [FRAC_BITS-1:0]   quo;
  logic                   ge;

  assign rem2 = {rem[COUNT_BITS-1:0], 1'b0};
  assign ge   = rem2 >= {1'b0, total};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem <= {1'b0, counts[cmd.bin]};
      quo <= '0;
    end else if (cmd.step) begin
      rem <= ge ? rem2 - {1'b0, total} : rem2;
      quo <= {quo[FRAC_BITS-2:0], ge};
    end
  end

  assign result.bin_index = cmd.bin;
  assign result.fraction  = quo;
  assign result.last_bin  = (cmd.bin == LAST_BIN);

endmodule

FILE: design/dominant_hue_histogram.sv
// Dominant hue histogram: top level joining dhh_ctrl and dhh_datapath.
// Depends on dhh_pkg.
//
// Pixels are taken one per clock while busy is low (start high). Every pixel
// counts toward the total; non-gray pixels add one to each of the eight hue
// bins whose center lies strictly within 30 degrees of the pixel hue. After
// the pixel marked last_pixel, busy stays high while the hue pipeline settles
// and then, per bin, for a load, 16 divider steps and a result cycle, the
// divider forming one quotient bit per clock. The eight results appear on
// result with result_valid high for one cycle each, bin 0 first; they cannot
// be stalled and must be captured when shown. Counters clear with the eighth
// result.
module dominant_hue_histogram import dhh_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  pixel_t  pixel,
  output logic    result_valid,
  output result_t result
);

  cmd_t cmd;

  dhh_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .last_pixel   (pixel.last_pixel),
    .busy         (busy),
    .result_valid (result_valid),
    .cmd          (cmd)
  );

  dhh_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .pixel  (pixel),
    .result (result)
  );

endmodule

FILE: design/dhh_checker.sv
// dhh_checker: port-level assertions for dominant_hue_histogram, bound to the
// top level below. Depends on dhh_pkg.
module dhh_checker import dhh_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input pixel_t  pixel,
  input logic    result_valid,
  input result_t result
);

  // results only come out while the block holds off new requests
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result shown while not busy");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.last_bin == (result.bin_index == LAST_BIN)))
    else $error("last_bin does not match final bin index");

  a_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last_bin |=> !result_valid)
    else $error("results back to back within one image");

  a_release: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_bin |=> !busy)
    else $error("busy held after final result");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    start && !busy && pixel.last_pixel |=> busy && !result_valid)
    else $error("last pixel request did not start normalization");

endmodule

bind dominant_hue_histogram dhh_checker u_dhh_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .pixel        (pixel),
  .result_valid (result_valid),
  .result       (result)
);

FILE: sim/dhh_checker.sv
// dhh_tb_checker: watches the pixel and result channels of the hue histogram,
// predicts the eight per-image bin fractions and compares them in order.
// Depends on dhh_pkg.
module dhh_tb_checker import dhh_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  pixel_t  pixel,
  input  logic    result_valid,
  input  result_t result,
  output int      errors,
  output int      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint COUNT_TOP = (longint'(1) << COUNT_BITS) - 1;
  localparam int HUE_CENTER_DEG [NUM_BINS] = '{0, 30, 60, 120, 180, 240, 270, 300};

  longint  pix_count;
  longint  bin_count [NUM_BINS];
  result_t fraction_due_q [$];
  result_t want;

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  function automatic longint bump(longint v);
    return (v >= COUNT_TOP) ? COUNT_TOP : v + 1;
  endfunction

  // One bit per center whose circular distance to the hue is below 30 deg.
  // Hue is kept scaled by (max - min) so all compares stay exact.
  function automatic logic [NUM_BINS-1:0] hue_hits(int r, int g, int b);
    int mx, mn, d, h, span;
    logic [NUM_BINS-1:0] hits;
    hits = '0;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    if (d == 0) return hits;
    if (mx == r) begin
      h = 60 * (g - b);
      if (h < 0) h += 360 * d;
    end else if (mx == g) begin
      h = 60 * (b - r) + 120 * d;
    end else begin
      h = 60 * (r - g) + 240 * d;
    end
    for (int k = 0; k < NUM_BINS; k++) begin
      span = h - HUE_CENTER_DEG[k] * d;
      if (span < 0) span = -span;
      if (span > 180 * d) span = 360 * d - span;
      hits[k] = (span < 30 * d);
    end
    return hits;
  endfunction

  function automatic void clear_counts();
    pix_count = 0;
    foreach (bin_count[k]) bin_count[k] = 0;
  endfunction

  function automatic void predict_pixel(pixel_t p);
    logic [NUM_BINS-1:0] hits;
    longint q;
    result_t r;
    pix_count = bump(pix_count);
    hits = hue_hits(int'(p.red), int'(p.green), int'(p.blue));
    for (int k = 0; k < NUM_BINS; k++)
      if (hits[k]) bin_count[k] = bump(bin_count[k]);
    if (p.last_pixel) begin
      for (int k = 0; k < NUM_BINS; k++) begin
        q = (bin_count[k] << FRAC_BITS) / pix_count;
        if (q > 65535) q = 65535;
        r.bin_index = BIN_BITS'(k);
        r.fraction  = FRAC_BITS'(q);
        r.last_bin  = (r.bin_index == LAST_BIN);
        fraction_due_q.push_back(r);
      end
      clear_counts();
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_counts();
      fraction_due_q.delete();
    end else begin
      if (result_valid) begin
        if (fraction_due_q.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected result bin=%0d frac=%0d last=%0b", $realtime,
                     result.bin_index, result.fraction, result.last_bin);
          errors++;
        end else begin
          want = fraction_due_q.pop_front();
          if (result.bin_index !== want.bin_index || result.fraction !== want.fraction ||
              result.last_bin !== want.last_bin) begin
            if (errors < 10)
              $display({"%0t: mismatch exp bin=%0d frac=%0d last=%0b",
                        " got bin=%0d frac=%0d last=%0b"},
                       $realtime, want.bin_index, want.fraction, want.last_bin,
                       result.bin_index, result.fraction, result.last_bin);
            errors++;
          end
        end
      end
      if (start && !busy) predict_pixel(pixel);
    end
    outstanding = fraction_due_q.size();
  end

endmodule

FILE: sim/tb_top.sv
// tb_top: clock, reset and pixel stimulus for dominant_hue_histogram; the
// dhh_tb_checker instance does prediction and comparison. Depends on dhh_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dhh_pkg::*;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  pixel_t  pixel = '0;
  logic    busy;
  logic    result_valid;
  result_t result;
  int      errors;
  int      outstanding;
  int      idle_pct = 0;
  int      random_sent;

  dominant_hue_histogram dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pixel(pixel), .result_valid(result_valid), .result(result)
  );

  dhh_tb_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pixel(pixel),
    .result_valid(result_valid), .result(result),
    .errors(errors), .outstanding(outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic last);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    pixel <= '{red: r, green: g, blue: b, last_pixel: last};
    do @(posedge clk); while (busy);
  endtask

  // Mix of gray, tied-maximum, primary/secondary and fully random colors.
  task automatic send_random_pixel(logic last);
    logic [7:0] r, g, b, v;
    v = 8'($urandom_range(255));
    r = 8'($urandom_range(255));
    g = 8'($urandom_range(255));
    b = 8'($urandom_range(255));
    case ($urandom_range(9))
      0: begin
        r = v; g = v; b = v;
      end
      1: begin
        case ($urandom_range(2))
          0: begin r = v; g = v; b = 8'($urandom_range(v)); end
          1: begin g = v; b = v; r = 8'($urandom_range(v)); end
          default: begin r = v; b = v; g = 8'($urandom_range(v)); end
        endcase
      end
      2: begin
        r = {8{r[0]}}; g = {8{g[0]}}; b = {8{b[0]}};
      end
      default: ;
    endcase
    send_pixel(r, g, b, last);
  endtask

  task automatic send_image(int len);
    for (int k = 1; k <= len; k++) send_random_pixel(k == len);
    random_sent += len;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-pixel images: black, white, pure red (full bin saturates)
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b1);
    // hues on two centers, ties for the maximum, a hue between centers
    send_pixel(8'd4, 8'd1, 8'd0, 1'b0);     // 15 deg
    send_pixel(8'd4, 8'd3, 8'd0, 1'b0);     // 45 deg
    send_pixel(8'd255, 8'd255, 8'd0, 1'b0); // red/green tie, 60 deg
    send_pixel(8'd0, 8'd255, 8'd255, 1'b0); // green/blue tie, 180 deg
    send_pixel(8'd255, 8'd0, 8'd255, 1'b0); // red/blue tie, 300 deg
    send_pixel(8'd2, 8'd4, 8'd0, 1'b0);     // 90 deg, no bin
    send_pixel(8'd1, 8'd0, 8'd4, 1'b0);     // 255 deg
    send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd128, 8'd0, 8'd255, 1'b0);
    send_pixel(8'd17, 8'd17, 8'd17, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd1, 1'b0);
    send_pixel(8'd255, 8'd254, 8'd0, 1'b0);
    send_pixel(8'd1, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd1, 8'd255, 1'b1);

    // idle phases: none, sender 60%, none, sender 23%
    random_sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 60 : (ph == 3) ? 23 : 0;
      while (random_sent < (ph + 1) * 80)
        send_image(($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10));
    end

    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (160) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
